>>> design/zcr_pkg.sv
// Shared constants for the zero-crossing clock recovery unit.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package zcr_pkg;

   // Defaults for the top-level parameters.
   localparam int AVG_WINDOW_DEFAULT    = 256;
   localparam int HISTORY_DEPTH_DEFAULT = 256;
   localparam int SAMPLE_BITS_DEFAULT   = 16;

   // Configuration register file.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int PULSE_LEN_W  = 8;
   localparam logic REG_PULSE_LEN = 1'b0;   // register index taken from paddr[2]
   localparam logic [PULSE_LEN_W-1:0] PULSE_LEN_RESET = 8'd8;

   // Pipeline depths.
   localparam int MEAN_LAT    = 4;             // stages in the mean unit
   localparam int FRONT_DEPTH = MEAN_LAT + 3;  // item-holding stages in the front part
   localparam int QUEUE_DEPTH = 16;            // crossing events between front and back

endpackage

>>> design/zcr_mean.sv
// Mean unit: floor(sum / AVG_WINDOW) over a fixed number of pipeline stages.
// Shift form for a power-of-two window, reciprocal multiply with correction otherwise.
// Depends on zcr_pkg.
`timescale 1ns / 1ps

module zcr_mean #(
   parameter int AVG_WINDOW  = zcr_pkg::AVG_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = zcr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   input  logic signed [SAMPLE_BITS+$clog2(AVG_WINDOW)-1:0]   in_sum,
   input  logic signed [SAMPLE_BITS-1:0]                      in_sample,
   output logic                                               out_valid,
   output logic signed [SAMPLE_BITS-1:0]                      out_mean,
   output logic signed [SAMPLE_BITS-1:0]                      out_sample
);

   localparam int K     = $clog2(AVG_WINDOW);
   localparam int SUM_W = SAMPLE_BITS + K;
   localparam int LAT   = zcr_pkg::MEAN_LAT;
   localparam bit IS_POW2 = (AVG_WINDOW == (1 << K));

   logic [LAT-1:0]                         vld_ff;
   logic [LAT-1:0][SAMPLE_BITS-1:0]        smp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= {smp_ff[LAT-2:0], in_sample};
   end

   assign out_valid  = vld_ff[LAT-1];
   assign out_sample = smp_ff[LAT-1];

   generate
      if (IS_POW2) begin : g_shift
         logic [LAT-1:0][SAMPLE_BITS-1:0] mean_ff;
         logic signed [SUM_W-1:0]         shifted;

         assign shifted = in_sum >>> K;

         always_ff @(posedge clock) begin
            mean_ff <= {mean_ff[LAT-2:0], shifted[SAMPLE_BITS-1:0]};
         end

         assign out_mean = mean_ff[LAT-1];
      end else begin : g_recip
         // The sum is offset by W * 2^(SAMPLE_BITS-1) to make it nonnegative; the
         // quotient estimate from the truncated reciprocal is exact or one low.
         localparam int XW   = SUM_W;
         localparam int LO_W = XW / 2;
         localparam int HI_W = XW - LO_W;
         localparam int MW   = SAMPLE_BITS + 1;
         localparam int PW   = XW + MW;
         localparam logic [63:0] RECIP    = (64'd1 << XW) / AVG_WINDOW;
         localparam logic [63:0] OFFSET   = 64'(AVG_WINDOW) << (SAMPLE_BITS - 1);
         localparam logic [63:0] WIN_CONST = 64'(AVG_WINDOW);

         logic [XW-1:0]        xoff;
         logic [LO_W+MW-1:0]   lo_pp_ff;
         logic [HI_W+MW-1:0]   hi_pp_ff;
         logic [XW-1:0]        x1_ff, x2_ff, x3_ff;
         logic [PW-1:0]        prod;
         logic [MW-1:0]        q2_ff, q3_ff;
         logic [XW-1:0]        qw3_ff;
         logic [XW-1:0]        rem;
         logic [MW-1:0]        q_fixed;
         logic [SAMPLE_BITS-1:0] mean_ff;

         assign xoff = in_sum + OFFSET[XW-1:0];
         assign prod = (PW'(hi_pp_ff) << LO_W) + PW'(lo_pp_ff);

         always_ff @(posedge clock) begin
            lo_pp_ff <= (LO_W+MW)'(xoff[LO_W-1:0]) * (LO_W+MW)'(RECIP[MW-1:0]);
            hi_pp_ff <= (HI_W+MW)'(xoff[XW-1:LO_W]) * (HI_W+MW)'(RECIP[MW-1:0]);
            x1_ff    <= xoff;
            q2_ff    <= prod[PW-1:XW];
            x2_ff    <= x1_ff;
            qw3_ff   <= XW'(q2_ff) * WIN_CONST[XW-1:0];
            q3_ff    <= q2_ff;
            x3_ff    <= x2_ff;
            mean_ff  <= q_fixed[SAMPLE_BITS-1:0] - {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end

         assign rem     = x3_ff - qw3_ff;
         assign q_fixed = q3_ff + MW'(rem >= WIN_CONST[XW-1:0]);
         assign out_mean = mean_ff;
      end
   endgenerate

endmodule

>>> design/zcr_front.sv
// Front part: moving-average window, centering, history ring and crossing detection.
// Produces one event per sign change with the looked-back sample and a repeat flag.
// Depends on zcr_pkg and zcr_mean.
`timescale 1ns / 1ps

module zcr_front #(
   parameter int AVG_WINDOW    = zcr_pkg::AVG_WINDOW_DEFAULT,
   parameter int HISTORY_DEPTH = zcr_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS   = zcr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_take,
   input  logic signed [SAMPLE_BITS-1:0]         in_sample,
   input  logic [zcr_pkg::PULSE_LEN_W-1:0]       pulse_len,
   output logic                                  evt_valid,
   output logic signed [SAMPLE_BITS:0]           evt_sample,
   output logic                                  evt_twice
);

   localparam int WW    = $clog2(AVG_WINDOW);
   localparam int SUM_W = SAMPLE_BITS + WW;
   localparam int HW    = $clog2(HISTORY_DEPTH);
   localparam int RUN_W = HW + 1;
   localparam int CMP_W = RUN_W + zcr_pkg::PULSE_LEN_W + 3;
   localparam logic [RUN_W-1:0] RUN_MAX  = RUN_W'(2 * HISTORY_DEPTH - 1);
   localparam logic [WW-1:0]    WIN_LAST = WW'(AVG_WINDOW - 1);
   localparam logic [HW-1:0]    HIS_LAST = HW'(HISTORY_DEPTH - 1);
   localparam logic [HW:0]      HIS_SIZE = (HW+1)'(HISTORY_DEPTH);

   // ---------------- window store and running sum ----------------
   logic signed [SAMPLE_BITS-1:0] win_mem [AVG_WINDOW];
   logic signed [SAMPLE_BITS-1:0] win_rd_ff;
   logic [WW-1:0]                 win_pos_ff;
   logic                          wrapped_ff;
   logic                          v1_ff, old_ok1_ff;
   logic signed [SAMPLE_BITS-1:0] s1_ff;
   logic                          v2_ff;
   logic signed [SAMPLE_BITS-1:0] s2_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [SAMPLE_BITS-1:0] old_val;

   // Slots ahead of the write position are read as zero until the position first wraps.
   always_ff @(posedge clock) begin
      if (in_take) begin
         win_rd_ff           <= win_mem[win_pos_ff];
         win_mem[win_pos_ff] <= in_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_pos_ff <= '0;
         wrapped_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         sum_ff     <= '0;
      end else begin
         v1_ff <= in_take;
         v2_ff <= v1_ff;
         if (in_take) begin
            win_pos_ff <= (win_pos_ff == WIN_LAST) ? '0 : win_pos_ff + 1'b1;
            if (win_pos_ff == WIN_LAST) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (v1_ff) begin
            sum_ff <= sum_ff + SUM_W'(s1_ff) - SUM_W'(old_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= in_sample;
      old_ok1_ff <= wrapped_ff;
      s2_ff      <= s1_ff;
   end

   assign old_val = old_ok1_ff ? win_rd_ff : '0;

   // ---------------- mean ----------------
   logic                          mv;
   logic signed [SAMPLE_BITS-1:0] m_mean, m_sample;

   zcr_mean #(
      .AVG_WINDOW (AVG_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_sum    (sum_ff),
      .in_sample (s2_ff),
      .out_valid (mv),
      .out_mean  (m_mean),
      .out_sample(m_sample)
   );

   // ---------------- history ring and crossing detection ----------------
   logic signed [SAMPLE_BITS:0] his_mem [HISTORY_DEPTH];
   logic signed [SAMPLE_BITS:0] his_rd_ff;
   logic signed [SAMPLE_BITS:0] centred;
   logic signed [SAMPLE_BITS:0] centred_ff;
   logic [HW-1:0]               his_pos_ff;
   logic [RUN_W-1:0]            run_ff;
   logic                        was_nonneg_ff;
   logic                        nonneg, crossing;
   logic [HW-1:0]               back;
   logic [HW:0]                 back_sum;
   logic [HW-1:0]               rd_addr;
   logic                        long_run;
   logic                        ev_ff, bypass_ff, twice_ff;

   assign centred  = (SAMPLE_BITS+1)'(m_sample) - (SAMPLE_BITS+1)'(m_mean);
   assign nonneg   = ~centred[SAMPLE_BITS];
   assign crossing = nonneg != was_nonneg_ff;
   assign back     = run_ff[RUN_W-1:1];
   assign back_sum = {1'b0, his_pos_ff} + ((his_pos_ff < back) ? HIS_SIZE : '0)
                     - {1'b0, back};
   assign rd_addr  = back_sum[HW-1:0];
   assign long_run = ({run_ff, 2'b00} + CMP_W'(0))
                     > (CMP_W'(pulse_len) + (CMP_W'(pulse_len) << 2));

   // The look-back slot is always one already written since reset, so the ring
   // needs no clearing; a look-back of zero takes the fresh value directly.
   always_ff @(posedge clock) begin
      if (mv) begin
         his_rd_ff           <= his_mem[rd_addr];
         his_mem[his_pos_ff] <= centred;
         centred_ff          <= centred;
         bypass_ff           <= (back == '0);
         twice_ff            <= long_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         his_pos_ff    <= '0;
         run_ff        <= '0;
         was_nonneg_ff <= 1'b1;
         ev_ff         <= 1'b0;
      end else begin
         ev_ff <= mv & crossing;
         if (mv) begin
            his_pos_ff    <= (his_pos_ff == HIS_LAST) ? '0 : his_pos_ff + 1'b1;
            was_nonneg_ff <= nonneg;
            if (crossing) begin
               run_ff <= '0;
            end else if (run_ff != RUN_MAX) begin
               run_ff <= run_ff + 1'b1;
            end
         end
      end
   end

   assign evt_valid  = ev_ff;
   assign evt_sample = bypass_ff ? centred_ff : his_rd_ff;
   assign evt_twice  = twice_ff;

endmodule

>>> design/zcr_queue.sv
// Short event queue between the front and back parts, with a free-slot count.
// Depends on zcr_pkg.
`timescale 1ns / 1ps

module zcr_queue #(
   parameter int DATA_W = zcr_pkg::SAMPLE_BITS_DEFAULT + 2
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   input  logic [DATA_W-1:0]                         push_data,
   input  logic                                      pop,
   output logic [DATA_W-1:0]                         pop_data,
   output logic                                      not_empty,
   output logic [$clog2(zcr_pkg::QUEUE_DEPTH+1)-1:0] free
);

   localparam int DEPTH = zcr_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [CW-1:0]     count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

   assign pop_data  = slot_ff[rd_ff];
   assign not_empty = (count_ff != '0);
   assign free      = CW'(DEPTH) - count_ff;

endmodule

>>> design/zcr_emit.sv
// Back part: turns queued events into result words, repeating a long-run sample.
// Holds the output register of the result channel. Depends on zcr_pkg.
`timescale 1ns / 1ps

module zcr_emit #(
   parameter int SAMPLE_BITS = zcr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_not_empty,
   input  logic [SAMPLE_BITS+1:0]       q_data,      // {twice, sample}
   output logic                         q_pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [SAMPLE_BITS:0]  out_sample,
   output logic                         out_last
);

   logic                        valid_ff;
   logic                        last_ff;
   logic                        second_ff;
   logic signed [SAMPLE_BITS:0] sample_ff;
   logic                        load;

   assign load  = ~valid_ff | out_ready;
   assign q_pop = load & ~second_ff & q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else if (load) begin
         if (second_ff) begin
            // Repeat of the held sample closes the pair.
            valid_ff  <= 1'b1;
            last_ff   <= 1'b1;
            second_ff <= 1'b0;
         end else if (q_not_empty) begin
            valid_ff  <= 1'b1;
            last_ff   <= ~q_data[SAMPLE_BITS+1];
            second_ff <= q_data[SAMPLE_BITS+1];
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sample_ff <= q_data[SAMPLE_BITS:0];
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;
   assign out_last   = last_ff;

endmodule

>>> design/zero_crossing_clock_recovery_unit.sv
// Zero-crossing clock recovery: one sample word accepted per cycle when the result side keeps up.
// A crossing passes the front pipe, the event queue and the output register before its word shows.
// One result word per cycle while rsp_tready is high; a long run yields two words per input word.
// Input stalls only when the 16-entry event queue could not absorb every word in the front pipe.
// Reset (synchronous, active high) clears control state; no clearing pass is needed.
`timescale 1ns / 1ps

module zero_crossing_clock_recovery_unit #(
   parameter int AVG_WINDOW    = zcr_pkg::AVG_WINDOW_DEFAULT,
   parameter int HISTORY_DEPTH = zcr_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS   = zcr_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,

   // Sample stream in.
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         req_tdata,   // [SAMPLE_BITS-1:0] sample_in

   // Recovered sample stream out.
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((SAMPLE_BITS+8)/8)*8-1:0]         rsp_tdata,   // [SAMPLE_BITS:0] sample_out
   output logic                                     rsp_tlast,   // last_of_run

   // Register port.
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [zcr_pkg::CSR_ADDR_W-1:0]           csr_paddr,
   input  logic [zcr_pkg::CSR_DATA_W-1:0]           csr_pwdata,
   output logic [zcr_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;
   localparam int CW    = $clog2(zcr_pkg::QUEUE_DEPTH + 1);
   localparam int EVT_W = SAMPLE_BITS + 2;

   // ------------------------------------------------------------------
   // Configuration register. The register index is address bit 2; the
   // pulse length is written on the access cycle of an APB write.
   // ------------------------------------------------------------------
   logic [zcr_pkg::PULSE_LEN_W-1:0] pulse_len_ff;
   logic [zcr_pkg::PULSE_LEN_W-1:0] pulse_len_in;
   logic                            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      pulse_len_in = pulse_len_ff;
      if (csr_wr && (csr_paddr[2] == zcr_pkg::REG_PULSE_LEN)) begin
         pulse_len_in = csr_pwdata[zcr_pkg::PULSE_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_len_ff <= zcr_pkg::PULSE_LEN_RESET;
      end else begin
         pulse_len_ff <= pulse_len_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == zcr_pkg::REG_PULSE_LEN)
                       ? zcr_pkg::CSR_DATA_W'(pulse_len_ff) : '0;

   // ------------------------------------------------------------------
   // Front part. The front pipe never stalls, so a word is accepted only
   // when the queue has a free slot for every word that could still be in
   // the pipe, the new one included.
   // ------------------------------------------------------------------
   logic                        take;
   logic                        evt_valid;
   logic signed [SAMPLE_BITS:0] evt_sample;
   logic                        evt_twice;
   logic [CW-1:0]               q_free;

   assign req_tready = (q_free > CW'(zcr_pkg::FRONT_DEPTH));
   assign take       = req_tvalid & req_tready;

   zcr_front #(
      .AVG_WINDOW   (AVG_WINDOW),
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_take   (take),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .pulse_len (pulse_len_ff),
      .evt_valid (evt_valid),
      .evt_sample(evt_sample),
      .evt_twice (evt_twice)
   );

   // ------------------------------------------------------------------
   // Event queue: each crossing leaves one entry, the repeat flag on top.
   // ------------------------------------------------------------------
   logic             q_pop;
   logic             q_not_empty;
   logic [EVT_W-1:0] q_data;

   zcr_queue #(
      .DATA_W(EVT_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (evt_valid),
      .push_data({evt_twice, evt_sample}),
      .pop      (q_pop),
      .pop_data (q_data),
      .not_empty(q_not_empty),
      .free     (q_free)
   );

   // ------------------------------------------------------------------
   // Back part: output register, with the second word of a long run
   // taken from the same held sample.
   // ------------------------------------------------------------------
   logic signed [SAMPLE_BITS:0] out_sample;

   zcr_emit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (out_sample),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = OUT_W'(unsigned'(out_sample));

endmodule
